FILE: rtl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared opcodes, function codes, access sizes and the execute result bundle.
// ----------------------------------------------------------------------------
package rvx_pkg;

	localparam logic [6:0] OP_R      = 7'b0110011;
	localparam logic [6:0] OP_I      = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	typedef struct packed {
		logic        ok;
		logic        wr;
		logic        st;
		logic        ld;
		logic        ld_sign;
		logic [4:0]  rd;
		logic [31:0] val;
		logic [31:0] addr;
		logic [31:0] mval;
		logic [1:0]  size;
		logic [31:0] next;
	} exec_res_t;

endpackage

FILE: rtl/rv32i_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit
// RV32I subset execute unit with register file, data memory and pc.
// ----------------------------------------------------------------------------
// Operands are read from the register file as the input transfers (into s1);
// execute and the data-memory access follow as the instruction moves from s1
// into the result register s2. Throughput: one instruction per cycle while
// out_stall is low and no clearing pass runs.
// Reset: pc clears to 0, then a clearing pass over max(DMEM_WORDS, 32) entries
// zeroes data memory and register file; input is stalled during the pass.
// DMEM_WORDS must be a power of two (word index wraps by masking).
module rv32i_subset_execute_unit #(
	parameter int DMEM_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] start_pc,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] executed_pc,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        mem_store,
	output logic [31:0] mem_address,
	output logic [31:0] mem_value,
	output logic [1:0]  mem_size,
	output logic        recognized
);
	import rvx_pkg::*;

	localparam int AW      = $clog2(DMEM_WORDS);
	localparam int CLR_LEN = (DMEM_WORDS > 32) ? DMEM_WORDS : 32;
	localparam int CW      = $clog2(CLR_LEN + 1);

	// clearing pass
	logic [CW-1:0] clr_cnt_q;
	logic          clearing;

	// pipeline control
	logic          v_s1, v_s2, en, accept, adv_s1, out_xfer;
	logic [31:0]   instr_s1, pc_s1, pc_q;
	exec_res_t     ex, ex_s2;
	logic [31:0]   pc_s2;

	// operands
	logic [31:0]   rf_a, rf_b, op_a, op_b;
	logic [4:0]    rs1_s1, rs2_s1;
	logic          lw_v_q;
	logic [4:0]    lw_idx_q;
	logic [31:0]   lw_val_q;

	// writeback and data memory
	logic          rf_wb, rf_we;
	logic [4:0]    rf_waddr;
	logic [31:0]   rf_wdata, wb_val, ld_word, ld_half;
	logic [7:0]    ld_byte;
	logic          dm_re, dm_st;
	logic [AW-1:0] dm_idx, dm_waddr;
	logic [3:0]    lane_we;
	logic [31:0]   st_data, dm_wdata;

	assign clearing  = (clr_cnt_q != CW'(CLR_LEN));
	assign cfg_ready = 1'b1;

	// the execute stage advances whenever the result register is free or drains
	assign en       = !v_s2 || !out_stall;
	assign adv_s1   = v_s1 && en;
	assign in_stall = clearing || (v_s1 && !en);
	assign accept   = in_valid && !in_stall;
	assign out_xfer = v_s2 && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			pc_q      <= '0;
			lw_v_q    <= 1'b0;
		end else begin
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (en) begin
				v_s1 <= 1'b0;
			end
			if (en) begin
				v_s2 <= v_s1;
			end
			// advance the pc as each instruction leaves execute; a config write
			// reloads it (to be taken only while the block is idle; the user must ensure this, the block does not)
			if (cfg_valid && cfg_ready) begin
				pc_q <= start_pc;
			end else if (adv_s1) begin
				pc_q <= ex.next;
			end
			if (rf_wb) begin
				lw_v_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr_word;
			pc_s1    <= adv_s1 ? ex.next : pc_q;
		end
		if (adv_s1) begin
			ex_s2 <= ex;
			pc_s2 <= pc_s1;
		end
		if (rf_wb) begin
			lw_idx_q <= ex_s2.rd;
			lw_val_q <= wb_val;
		end
	end

	// register file: two copies give two read ports; written as results leave
	assign rf_wb    = out_xfer && ex_s2.wr;
	assign rf_we    = clearing || rf_wb;
	assign rf_waddr = clearing ? clr_cnt_q[4:0] : ex_s2.rd;
	assign rf_wdata = clearing ? 32'd0 : wb_val;

	rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(accept), .raddr(instr_word[19:15]), .rdata(rf_a)
	);

	rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(accept), .raddr(instr_word[24:20]), .rdata(rf_b)
	);

	// forward: the result waiting in s2 first, then the write that landed on
	// the same edge as the operand read
	assign rs1_s1 = instr_s1[19:15];
	assign rs2_s1 = instr_s1[24:20];

	always_comb begin
		if (v_s2 && ex_s2.wr && ex_s2.rd == rs1_s1) begin
			op_a = wb_val;
		end else if (lw_v_q && lw_idx_q == rs1_s1) begin
			op_a = lw_val_q;
		end else begin
			op_a = rf_a;
		end
		if (v_s2 && ex_s2.wr && ex_s2.rd == rs2_s1) begin
			op_b = wb_val;
		end else if (lw_v_q && lw_idx_q == rs2_s1) begin
			op_b = lw_val_q;
		end else begin
			op_b = rf_b;
		end
	end

	rvx_exec u_exec (
		.instr(instr_s1), .pc(pc_s1), .a(op_a), .b(op_b), .res(ex)
	);

	// data memory: four byte lanes; loads read and stores write as the
	// instruction leaves execute, so memory order follows program order
	assign dm_idx   = ex.addr[AW+1:2];
	assign dm_re    = adv_s1 && ex.ld;
	assign dm_st    = adv_s1 && ex.st;
	assign dm_waddr = clearing ? clr_cnt_q[AW-1:0] : dm_idx;

	always_comb begin
		case (ex.size)
			SZ_WORD: begin
				st_data = ex.mval;
				lane_we = 4'b1111;
			end
			SZ_HALF: begin
				st_data = {2{ex.mval[15:0]}};
				lane_we = ex.addr[1] ? 4'b1100 : 4'b0011;
			end
			default: begin
				st_data = {4{ex.mval[7:0]}};
				lane_we = 4'b0001 << ex.addr[1:0];
			end
		endcase
	end

	assign dm_wdata = clearing ? 32'd0 : st_data;

	for (genvar g = 0; g < 4; g++) begin : g_lane
		rvx_ram #(.WIDTH(8), .DEPTH(DMEM_WORDS)) u_dm (
			.clk(clk), .we(clearing || (dm_st && lane_we[g])), .waddr(dm_waddr),
			.wdata(dm_wdata[8*g +: 8]), .re(dm_re), .raddr(dm_idx),
			.rdata(ld_word[8*g +: 8])
		);
	end

	// load alignment and extension
	assign ld_half = ex_s2.addr[1] ? {16'd0, ld_word[31:16]} : {16'd0, ld_word[15:0]};
	always_comb begin
		case (ex_s2.addr[1:0])
			2'd0:    ld_byte = ld_word[7:0];
			2'd1:    ld_byte = ld_word[15:8];
			2'd2:    ld_byte = ld_word[23:16];
			default: ld_byte = ld_word[31:24];
		endcase
	end

	always_comb begin
		wb_val = ex_s2.val;
		if (ex_s2.ld && ex_s2.wr) begin
			case (ex_s2.size)
				SZ_WORD: wb_val = ld_word;
				SZ_HALF: wb_val = ex_s2.ld_sign ? {{16{ld_half[15]}}, ld_half[15:0]} : ld_half;
				default: wb_val = ex_s2.ld_sign ? {{24{ld_byte[7]}}, ld_byte} : {24'd0, ld_byte};
			endcase
		end
	end

	// result
	assign out_valid   = v_s2;
	assign executed_pc = pc_s2;
	assign next_pc     = ex_s2.next;
	assign reg_write   = ex_s2.wr;
	assign reg_index   = ex_s2.rd;
	assign reg_value   = wb_val;
	assign mem_store   = ex_s2.st;
	assign mem_address = ex_s2.addr;
	assign mem_value   = ex_s2.mval;
	assign mem_size    = ex_s2.size;
	assign recognized  = ex_s2.ok;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept) else $error("transfer accepted during clearing pass");

	a_no_ld_st_same: assert property (@(posedge clk) disable iff (!arst_n)
		!(dm_re && dm_st)) else $error("load and store issued together");

	a_pc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !(cfg_valid && cfg_ready) |=> v_s2 && pc_q == $past(ex.next))
		else $error("pc did not follow executed instruction");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wb |-> ex_s2.rd != 5'd0) else $error("write to x0");
endmodule

FILE: rtl/rvx_ram.sv
// ----------------------------------------------------------------------------
// rvx_ram
// Generic one-write one-read RAM with registered, read-first read data.
// ----------------------------------------------------------------------------
module rvx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/rvx_exec.sv
// ----------------------------------------------------------------------------
// rvx_exec
// Decode and execute of one instruction with its operands already read.
// ----------------------------------------------------------------------------
module rvx_exec (
	input  logic [31:0]            instr,
	input  logic [31:0]            pc,
	input  logic [31:0]            a,
	input  logic [31:0]            b,
	output rvx_pkg::exec_res_t     res
);
	import rvx_pkg::*;

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4, sum_i;
	logic        take;

	assign op    = instr[6:0];
	assign f3    = instr[14:12];
	assign f7    = instr[31:25];
	assign imm_i = {{20{instr[31]}}, instr[31:20]};
	assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
	assign pc4   = pc + 32'd4;
	assign sum_i = a + imm_i;

	always_comb begin
		case (f3)
			F3_BEQ:  take = (a == b);
			F3_BNE:  take = (a != b);
			F3_BLT:  take = ($signed(a) < $signed(b));
			F3_BGE:  take = ($signed(a) >= $signed(b));
			F3_BLTU: take = (a < b);
			default: take = (a >= b);
		endcase
	end

	always_comb begin
		res         = '0;
		res.rd      = instr[11:7];
		res.next    = pc4;
		res.ld_sign = ~f3[2];
		case (op)
			OP_R: begin
				if (f7 == F7_BASE || (f7 == F7_ALT && f3 == F3_ADD)) begin
					res.ok = 1'b1;
					res.wr = 1'b1;
					case (f3)
						F3_ADD:  res.val = (f7 == F7_ALT) ? a - b : a + b;
						F3_SLL:  res.val = a << b[4:0];
						F3_SLTU: res.val = {31'd0, a < b};
						F3_XOR:  res.val = a ^ b;
						F3_SRL:  res.val = a >> b[4:0];
						F3_OR:   res.val = a | b;
						F3_AND:  res.val = a & b;
						default: begin
							res.ok = 1'b0;
							res.wr = 1'b0;
						end
					endcase
				end
			end
			OP_I: begin
				res.ok = 1'b1;
				res.wr = 1'b1;
				case (f3)
					F3_ADD:  res.val = sum_i;
					F3_SLL:  res.val = a << imm_i[4:0];
					F3_SLTU: res.val = {31'd0, a < imm_i};
					F3_XOR:  res.val = a ^ imm_i;
					F3_SRL: begin
						if (instr[30]) begin
							res.ok = 1'b0;
							res.wr = 1'b0;
						end else begin
							res.val = a >> imm_i[4:0];
						end
					end
					F3_OR:   res.val = a | imm_i;
					F3_AND:  res.val = a & imm_i;
					default: begin
						res.ok = 1'b0;
						res.wr = 1'b0;
					end
				endcase
			end
			OP_JAL: begin
				res.ok   = 1'b1;
				res.wr   = 1'b1;
				res.val  = pc4;
				res.next = pc + imm_j;
			end
			OP_JALR: begin
				if (f3 == F3_ADD) begin
					res.ok   = 1'b1;
					res.wr   = 1'b1;
					res.val  = pc4;
					res.next = {sum_i[31:1], 1'b0};
				end
			end
			OP_BRANCH: begin
				if (f3 != F3_SLT && f3 != F3_SLTU) begin
					res.ok = 1'b1;
					if (take) begin
						res.next = pc + imm_b;
					end
				end
			end
			OP_LOAD: begin
				if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU
						|| f3 == F3_LHU) begin
					res.ok   = 1'b1;
					res.wr   = 1'b1;
					res.ld   = 1'b1;
					res.addr = sum_i;
					res.size = f3[1:0];
				end
			end
			OP_STORE: begin
				if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW) begin
					res.ok   = 1'b1;
					res.st   = 1'b1;
					res.addr = a + imm_s;
					res.mval = b;
					res.size = f3[1:0];
				end
			end
			default: res.ok = 1'b0;
		endcase
		// drop writes to x0
		if (res.rd == 5'd0) begin
			res.wr  = 1'b0;
			res.val = '0;
		end
		if (!res.wr) begin
			res.val = '0;
			res.rd  = 5'd0;
		end
	end
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RV32I subset execute unit testbench
// Drives instruction words through the stall handshake and compares each result
// against its typed table row or an in-bench model of pc, registers and memory.
// ----------------------------------------------------------------------------
module testbench;
	import rvx_pkg::*;

	localparam int MEM_WORDS  = 1024;
	localparam int WATCHDOG   = 20000;
	localparam int N_RANDOM   = 1450;
	localparam int N_DIRECTED = 22;

	typedef struct packed {
		logic [31:0] executed_pc;
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_store;
		logic [31:0] mem_address;
		logic [31:0] mem_value;
		logic [1:0]  mem_size;
		logic        recognized;
	} retire_t;

	typedef struct {
		logic [31:0] word;
		logic        typed;
		retire_t     want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] start_pc = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instr_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	retire_t     got;

	// model state
	logic [31:0] pc_q;
	logic [31:0] xreg [32];
	logic [31:0] dmem [MEM_WORDS];

	retire_t     pending_q[$];
	retire_t     typed_q[$];
	logic        typed_flag_q[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          hold_off = 1'b0;
	stim_row_t   directed [N_DIRECTED];

	always #5 clk = ~clk;

	rv32i_subset_execute_unit #(.DMEM_WORDS(MEM_WORDS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .start_pc(start_pc),
		.in_valid(in_valid), .in_stall(in_stall), .instr_word(instr_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.executed_pc(got.executed_pc), .next_pc(got.next_pc),
		.reg_write(got.reg_write), .reg_index(got.reg_index),
		.reg_value(got.reg_value), .mem_store(got.mem_store),
		.mem_address(got.mem_address), .mem_value(got.mem_value),
		.mem_size(got.mem_size), .recognized(got.recognized)
	);

	function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
		logic [31:0] m;
		m = 32'd1 << (bits - 1);
		v = v & ((m << 1) - 1);
		return (v ^ m) - m;
	endfunction

	// execute one instruction on the model and advance its state
	function automatic retire_t execute_instr(input logic [31:0] w);
		retire_t r;
		logic [6:0] op; logic [4:0] rd; logic [2:0] f3; logic [6:0] f7;
		logic [31:0] a, b, ii, is, ib, ij, nxt, val, addr, wd, m;
		logic ok, wr, st, take;
		int idx, sh;
		op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
		a = xreg[w[19:15]]; b = xreg[w[24:20]];
		ii = sx({20'd0, w[31:20]}, 12);
		is = sx({20'd0, w[31:25], w[11:7]}, 12);
		ib = sx({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
		ij = sx({11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
		nxt = pc_q + 4; ok = 0; wr = 0; st = 0; val = 0; addr = 0;
		r = '0;
		if (op == OP_R && (f7 == F7_BASE || (f7 == F7_ALT && f3 == F3_ADD))) begin
			ok = 1; wr = 1;
			case (f3)
				F3_ADD:  val = (f7 == F7_ALT) ? a - b : a + b;
				F3_SLL:  val = a << b[4:0];
				F3_SLTU: val = {31'd0, a < b};
				F3_XOR:  val = a ^ b;
				F3_SRL:  val = a >> b[4:0];
				F3_OR:   val = a | b;
				F3_AND:  val = a & b;
				default: begin ok = 0; wr = 0; end
			endcase
		end else if (op == OP_I) begin
			ok = 1; wr = 1;
			case (f3)
				F3_ADD:  val = a + ii;
				F3_SLL:  val = a << ii[4:0];
				F3_SLTU: val = {31'd0, a < ii};
				F3_XOR:  val = a ^ ii;
				F3_SRL: begin
					if (w[30]) begin ok = 0; wr = 0; end
					else val = a >> ii[4:0];
				end
				F3_OR:   val = a | ii;
				F3_AND:  val = a & ii;
				default: begin ok = 0; wr = 0; end
			endcase
		end else if (op == OP_JAL) begin
			ok = 1; wr = 1; val = pc_q + 4; nxt = pc_q + ij;
		end else if (op == OP_JALR && f3 == F3_ADD) begin
			ok = 1; wr = 1; val = pc_q + 4; nxt = (a + ii) & ~32'd1;
		end else if (op == OP_BRANCH && f3 != F3_SLT && f3 != F3_SLTU) begin
			ok = 1;
			case (f3)
				F3_BEQ:  take = a == b;
				F3_BNE:  take = a != b;
				F3_BLT:  take = $signed(a) < $signed(b);
				F3_BGE:  take = $signed(a) >= $signed(b);
				F3_BLTU: take = a < b;
				default: take = a >= b;
			endcase
			if (take) nxt = pc_q + ib;
		end else if (op == OP_LOAD && f3 != 3'd3 && f3 < 3'd6) begin
			ok = 1; wr = 1; addr = a + ii;
			wd = dmem[(addr >> 2) % MEM_WORDS];
			r.mem_size = f3[1:0];
			if (f3[1:0] == SZ_WORD) val = wd;
			else if (f3[1:0] == SZ_HALF) begin
				val = (wd >> (16 * addr[1])) & 32'hFFFF;
				if (f3 == F3_LH) val = sx(val, 16);
			end else begin
				val = (wd >> (8 * addr[1:0])) & 32'hFF;
				if (f3 == F3_LB) val = sx(val, 8);
			end
		end else if (op == OP_STORE && f3 < 3'd3) begin
			ok = 1; st = 1; addr = a + is;
			r.mem_value = b; r.mem_size = f3[1:0];
			idx = (addr >> 2) % MEM_WORDS;
			if (f3[1:0] == SZ_WORD) dmem[idx] = b;
			else begin
				if (f3[1:0] == SZ_HALF) begin sh = 16 * addr[1]; m = 32'hFFFF; end
				else begin sh = 8 * addr[1:0]; m = 32'hFF; end
				dmem[idx] = (dmem[idx] & ~(m << sh)) | ((b & m) << sh);
			end
		end
		if (rd == 5'd0) wr = 0;
		if (wr) xreg[rd] = val;
		r.executed_pc = pc_q; r.next_pc = nxt;
		r.reg_write = wr; r.reg_index = wr ? rd : 5'd0; r.reg_value = wr ? val : 32'd0;
		r.mem_store = st; r.mem_address = addr; r.recognized = ok;
		pc_q = nxt;
		return r;
	endfunction

	function automatic void model_reset();
		pc_q = '0;
		foreach (xreg[i]) xreg[i] = '0;
		foreach (dmem[i]) dmem[i] = '0;
	endfunction

	// random instruction: mostly well-formed with small addresses, some noise
	function automatic logic [31:0] rand_instr();
		logic [31:0] w;
		int pick;
		w = $urandom;
		pick = $urandom_range(0, 19);
		case (pick)
			0, 1, 2:  begin w[6:0] = OP_R; w[31:25] = $urandom_range(0, 3) == 0 ? F7_ALT : F7_BASE; end
			3, 4, 5, 6: w[6:0] = OP_I;
			7, 8, 9:  begin
				w[6:0] = OP_LOAD; w[14:12] = 3'($urandom_range(0, 5));
				if ($urandom_range(0, 3) != 0) w[19:15] = 5'($urandom_range(0, 3));
			end
			10, 11, 12: begin
				w[6:0] = OP_STORE; w[14:12] = 3'($urandom_range(0, 2));
				if ($urandom_range(0, 3) != 0) w[19:15] = 5'($urandom_range(0, 3));
			end
			13, 14:   w[6:0] = OP_BRANCH;
			15:       w[6:0] = OP_JAL;
			16:       begin w[6:0] = OP_JALR; w[14:12] = $urandom_range(0, 7) == 0 ? F3_SLL : F3_ADD; end
			default:  ;
		endcase
		return w;
	endfunction

	// stall behavior: short random stalls, a long hold-off on request
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// scoreboard and watchdog
	always @(posedge clk) begin
		retire_t e;
		bit      typed;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				typed = typed_flag_q.pop_front();
				if (typed) e = typed_q.pop_front();
				if (got.executed_pc !== e.executed_pc) begin
					$error("executed_pc exp %h got %h", e.executed_pc, got.executed_pc); errors++; end
				if (got.next_pc !== e.next_pc) begin
					$error("next_pc exp %h got %h", e.next_pc, got.next_pc); errors++; end
				if (got.reg_write !== e.reg_write) begin
					$error("reg_write exp %h got %h", e.reg_write, got.reg_write); errors++; end
				if (got.reg_index !== e.reg_index) begin
					$error("reg_index exp %h got %h", e.reg_index, got.reg_index); errors++; end
				if (got.reg_value !== e.reg_value) begin
					$error("reg_value exp %h got %h", e.reg_value, got.reg_value); errors++; end
				if (got.mem_store !== e.mem_store) begin
					$error("mem_store exp %h got %h", e.mem_store, got.mem_store); errors++; end
				if (got.mem_address !== e.mem_address) begin
					$error("mem_address exp %h got %h", e.mem_address, got.mem_address); errors++; end
				if (got.mem_value !== e.mem_value) begin
					$error("mem_value exp %h got %h", e.mem_value, got.mem_value); errors++; end
				if (got.mem_size !== e.mem_size) begin
					$error("mem_size exp %h got %h", e.mem_size, got.mem_size); errors++; end
				if (got.recognized !== e.recognized) begin
					$error("recognized exp %h got %h", e.recognized, got.recognized); errors++; end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// offer one instruction and hold it until the transfer
	task automatic send_instr(input logic [31:0] w, input bit typed, input retire_t want);
		retire_t r;
		in_valid <= 1'b1;
		instr_word <= w;
		do @(posedge clk); while (in_stall);
		r = execute_instr(w);
		pending_q.push_back(r);
		typed_flag_q.push_back(typed);
		if (typed) typed_q.push_back(want);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_pc(input logic [31:0] v);
		cfg_valid <= 1'b1;
		start_pc <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pc_q = v;
	endtask

	function automatic stim_row_t row(input logic [31:0] w);
		stim_row_t s;
		s.word = w; s.typed = 1'b0; s.want = '0;
		return s;
	endfunction

	function automatic stim_row_t row_typed(input logic [31:0] w, input retire_t r);
		stim_row_t s;
		s.word = w; s.typed = 1'b1; s.want = r;
		return s;
	endfunction

	initial begin
		retire_t t;
		int burst;
		int phase;
		model_reset();
		// directed table; first rows run from pc 0 after reset
		t = '0; t.next_pc = 32'd4;
		directed[0] = row_typed(32'h0000_0037, t);            // LUI: not executed
		t = '0; t.executed_pc = 32'd4; t.next_pc = 32'd8; t.recognized = 1;
		directed[1] = row_typed(32'h0000_0013, t);            // ADDI x0: write dropped
		t = '0; t.executed_pc = 32'd8; t.next_pc = 32'd12; t.recognized = 1;
		t.reg_write = 1; t.reg_index = 5'd1; t.reg_value = 32'hFFFF_F800;
		directed[2] = row_typed(32'h8000_0093, t);            // ADDI x1,x0,-2048
		t = '0; t.executed_pc = 32'd12; t.next_pc = 32'd16; t.recognized = 1;
		t.reg_write = 1; t.reg_index = 5'd2; t.reg_value = 32'h0000_07FF;
		directed[3] = row_typed(32'h7FF0_0113, t);            // ADDI x2,x0,2047
		t = '0; t.executed_pc = 32'd16; t.next_pc = 32'd20;
		directed[4] = row_typed(32'h0000_0073, t);            // ECALL
		directed[5]  = row(32'h4020_81B3);                    // SUB x3,x1,x2
		directed[6]  = row(32'h0020_9233);                    // SLL x4,x1,x2 (mask 5 bits)
		directed[7]  = row(32'h0020_D2B3);                    // SRL x5
		directed[8]  = row(32'hFFF0_B313);                    // SLTIU x6,x1,-1
		directed[9]  = row(32'hFFF0_9393);                    // SLLI with high imm bits
		directed[10] = row(32'h41F0_D413);                    // SRAI: not executed
		directed[11] = row(32'h0010_A023);                    // SW x1,0(x1) wraps
		directed[12] = row(32'h0020_90A3);                    // SH misaligned
		directed[13] = row(32'h0020_8123);                    // SB
		directed[14] = row(32'h0000_A483);                    // LW x9,0(x1)
		directed[15] = row(32'h0010_9503);                    // LH misaligned
		directed[16] = row(32'h0030_C583);                    // LBU
		directed[17] = row(32'h0000_8003);                    // LB to x0
		directed[18] = row(32'h0020_C463);                    // BLT taken
		directed[19] = row(32'hFE20_FEE3);                    // BGEU back
		directed[20] = row(32'hFFFF_F06F);                    // JAL x0,-2
		directed[21] = row(32'hFFF1_0667);                    // JALR x12,-1(x2)

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_instr(directed[i].word, directed[i].typed, directed[i].want);
		drop_valid();
		drain();

		// random phases under different start addresses, extremes included
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_start_pc(32'hFFFF_FFFC);
				1: write_start_pc(32'h0000_0000);
				2: write_start_pc(32'hFFFF_FFFF);
				default: write_start_pc($urandom);
			endcase
			if (phase == 3) hold_off = 1'b1;
			for (int n = 0; n < N_RANDOM / 5; ) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && n < N_RANDOM / 5; k++, n++)
					send_instr(rand_instr(), 1'b0, '0);
				if ($urandom_range(0, 2) != 0)
					repeat ($urandom_range(1, 5)) drop_valid();
				if (phase == 3 && n > 40) hold_off = 1'b0;
			end
			hold_off = 1'b0;
			drop_valid();
			drain();
		end
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hold-off length is counted here while the sender keeps offering
	always @(posedge clk) begin
		if (hold_off) begin
			repeat (60) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

endmodule
